@@ rtl/core/gblit_pkg.sv @@
package gblit_pkg;

	localparam int GLYPH_ROWS   = 8;
	localparam int GLYPH_COLS   = 8;
	localparam int GLYPH_COUNT  = 256;
	localparam int QUEUE_DEPTH  = 2;
	localparam int GLYPH_W      = 8;
	localparam int ADDR_W       = 48;
	localparam int WORD_W       = 32;
	localparam int IDX_W        = 27;
	localparam int CFG_IDX_W    = 3;

	localparam logic [2:0] LAST_IDX = 3'(GLYPH_ROWS - 1);

	localparam logic [7:0] FIRST_PRINTABLE = 8'h20;
	localparam logic [7:0] LAST_PRINTABLE  = 8'h7E;
	localparam logic [WORD_W-1:0] WHITE_WORD = 32'h00FF_FFFF;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PIX_FMT       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_STRIDE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BASE    = 3'd4;

	// pixel formats
	localparam logic [1:0] FMT_RGB = 2'd0;
	localparam logic [1:0] FMT_BGR = 2'd1;

	// result status codes
	localparam logic [1:0] STATUS_OK            = 2'd0;
	localparam logic [1:0] STATUS_NOT_PRINTABLE = 2'd1;
	localparam logic [1:0] STATUS_OFF_SCREEN    = 2'd2;

	typedef enum logic [1:0] {
		CMD_LOAD = 2'd0,
		CMD_DRAW = 2'd1,
		CMD_ERR  = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		logic [1:0]        pix_fmt;
		logic [12:0]       screen_height;
		logic [12:0]       screen_width;
		logic [13:0]       row_stride;
		logic [ADDR_W-1:0] frame_base;
	} cfg_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [1:0]         status;
		logic [7:0]         code;
		logic [2:0]         line;
		logic [GLYPH_W-1:0] bits;
		logic [IDX_W-1:0]   index0;
		logic [WORD_W-1:0]  fg;
		logic [WORD_W-1:0]  bg;
	} cmd_t;

	function automatic logic [WORD_W-1:0] pack_colour(
		input logic [1:0] fmt,
		input logic [7:0] r,
		input logic [7:0] g,
		input logic [7:0] b
	);
		logic [WORD_W-1:0] w;
		unique case (fmt)
			FMT_RGB: w = {8'h00, b, g, r};
			FMT_BGR: w = {8'h00, r, g, b};
			default: w = WHITE_WORD;
		endcase
		return w;
	endfunction

endpackage

@@ rtl/core/gblit_ram.sv @@
module gblit_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/core/gblit_queue.sv @@
module gblit_queue #(
	parameter int DEPTH = gblit_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  gblit_pkg::cmd_t   push_data,
	output logic              full,
	input  logic              pop,
	output gblit_pkg::cmd_t   head,
	output logic              empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	gblit_pkg::cmd_t mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

@@ rtl/core/gblit_front.sv @@
module gblit_front #(
	parameter int GLYPH_COUNT = gblit_pkg::GLYPH_COUNT
) (
	input  gblit_pkg::cfg_t  cfg,
	input  logic             push,
	output logic             full,
	input  logic             opcode,
	input  logic [11:0]      cell_row,
	input  logic [11:0]      cell_col,
	input  logic [7:0]       char_code,
	input  logic [7:0]       fg_red,
	input  logic [7:0]       fg_green,
	input  logic [7:0]       fg_blue,
	input  logic [7:0]       bg_red,
	input  logic [7:0]       bg_green,
	input  logic [7:0]       bg_blue,
	input  logic [2:0]       glyph_line,
	input  logic [7:0]       glyph_bits,
	input  logic             q_full,
	output logic             q_push,
	output gblit_pkg::cmd_t  q_data
);

	logic known_code;
	logic printable;
	logic off_screen;
	logic accept;

	assign full   = q_full;
	assign accept = push && !q_full;

	assign known_code = ({1'b0, char_code} < 9'(GLYPH_COUNT));
	assign printable  = known_code && (char_code >= gblit_pkg::FIRST_PRINTABLE)
		&& (char_code <= gblit_pkg::LAST_PRINTABLE);
	assign off_screen =
		(({1'b0, cell_row} + 13'(gblit_pkg::GLYPH_ROWS)) > cfg.screen_height) ||
		(({1'b0, cell_col} + 13'(gblit_pkg::GLYPH_COLS)) > cfg.screen_width);

	// drop loads aimed past the font store
	assign q_push = accept && !(opcode && !known_code);

	always_comb begin
		q_data.code   = char_code;
		q_data.line   = glyph_line;
		q_data.bits   = glyph_bits;
		q_data.index0 = gblit_pkg::IDX_W'(cell_row) * gblit_pkg::IDX_W'(cfg.row_stride)
			+ gblit_pkg::IDX_W'(cell_col);
		q_data.fg     = gblit_pkg::pack_colour(cfg.pix_fmt, fg_red, fg_green, fg_blue);
		q_data.bg     = gblit_pkg::pack_colour(cfg.pix_fmt, bg_red, bg_green, bg_blue);
		q_data.status = gblit_pkg::STATUS_OK;
		if (opcode) begin
			q_data.kind = gblit_pkg::CMD_LOAD;
		end else if (!printable) begin
			q_data.kind   = gblit_pkg::CMD_ERR;
			q_data.status = gblit_pkg::STATUS_NOT_PRINTABLE;
		end else if (off_screen) begin
			q_data.kind   = gblit_pkg::CMD_ERR;
			q_data.status = gblit_pkg::STATUS_OFF_SCREEN;
		end else begin
			q_data.kind = gblit_pkg::CMD_DRAW;
		end
	end

endmodule

@@ rtl/core/gblit_back.sv @@
module gblit_back #(
	parameter int GLYPH_COUNT = gblit_pkg::GLYPH_COUNT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  gblit_pkg::cfg_t                cfg,
	input  logic                           q_empty,
	input  gblit_pkg::cmd_t                q_head,
	output logic                           q_pop,
	output logic                           empty,
	input  logic                           pop,
	output logic                           write_enable,
	output logic [gblit_pkg::ADDR_W-1:0]   byte_address,
	output logic [gblit_pkg::WORD_W-1:0]   pixel_word,
	output logic [1:0]                     status,
	output logic                           last
);

	localparam int CODE_W = $clog2(GLYPH_COUNT);
	localparam int DEPTH  = GLYPH_COUNT * gblit_pkg::GLYPH_ROWS;
	localparam int RAM_AW = $clog2(DEPTH);
	localparam int AW     = gblit_pkg::ADDR_W;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_DRAW = 2'b10
	} state_t;

	state_t                        state_q;
	logic                          out_valid_q;
	logic [7:0]                    code_q;
	logic [2:0]                    dx_q;
	logic [2:0]                    dy_q;
	logic [AW-1:0]                 pix_addr_q;
	logic [AW-1:0]                 row_addr_q;
	logic [gblit_pkg::WORD_W-1:0]  fg_q;
	logic [gblit_pkg::WORD_W-1:0]  bg_q;

	logic                          advance;
	logic                          emit;
	logic                          emit_we;
	logic [AW-1:0]                 emit_addr;
	logic [gblit_pkg::WORD_W-1:0]  emit_word;
	logic [1:0]                    emit_status;
	logic                          emit_last;
	logic                          start_draw;
	logic                          step;
	logic                          ram_we;
	logic                          ram_re;
	logic [RAM_AW-1:0]             ram_waddr;
	logic [RAM_AW-1:0]             ram_raddr;
	logic [gblit_pkg::GLYPH_W-1:0] ram_rdata;
	logic [AW-1:0]                 stride4;
	logic [AW-1:0]                 start_addr;
	logic [AW-1:0]                 next_row_addr;

	assign empty   = !out_valid_q;
	assign advance = !out_valid_q || pop;

	assign stride4       = {{(AW - 16){1'b0}}, cfg.row_stride, 2'b00};
	assign start_addr    = cfg.frame_base
		+ {{(AW - gblit_pkg::IDX_W - 2){1'b0}}, q_head.index0, 2'b00};
	assign next_row_addr = row_addr_q + stride4;

	assign ram_waddr = {q_head.code[CODE_W-1:0], q_head.line};
	assign ram_raddr = start_draw ? {q_head.code[CODE_W-1:0], 3'd0}
		: {code_q[CODE_W-1:0], dx_q + 3'd1};

	gblit_ram #(
		.WIDTH(gblit_pkg::GLYPH_W),
		.DEPTH(DEPTH)
	) u_font (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(q_head.bits),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		q_pop       = 1'b0;
		ram_we      = 1'b0;
		ram_re      = 1'b0;
		start_draw  = 1'b0;
		step        = 1'b0;
		emit        = 1'b0;
		emit_we     = 1'b0;
		emit_addr   = '0;
		emit_word   = '0;
		emit_status = gblit_pkg::STATUS_OK;
		emit_last   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					unique case (q_head.kind)
						gblit_pkg::CMD_LOAD: begin
							q_pop  = 1'b1;
							ram_we = 1'b1;
						end
						gblit_pkg::CMD_DRAW: begin
							q_pop      = 1'b1;
							start_draw = 1'b1;
							ram_re     = 1'b1;
						end
						gblit_pkg::CMD_ERR: begin
							if (advance) begin
								q_pop       = 1'b1;
								emit        = 1'b1;
								emit_status = q_head.status;
								emit_last   = 1'b1;
							end
						end
						default: begin
							q_pop = 1'b1;
						end
					endcase
				end
			end
			ST_DRAW: begin
				if (advance) begin
					emit      = 1'b1;
					step      = 1'b1;
					emit_we   = 1'b1;
					emit_addr = pix_addr_q;
					emit_word = ram_rdata[dy_q] ? fg_q : bg_q;
					emit_last = (dx_q == gblit_pkg::LAST_IDX) && (dy_q == gblit_pkg::LAST_IDX);
					// fetch the next glyph row while the last pixel of this one goes out
					ram_re    = (dy_q == gblit_pkg::LAST_IDX) && (dx_q != gblit_pkg::LAST_IDX);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (start_draw) begin
				state_q <= ST_DRAW;
			end else if (step && emit_last) begin
				state_q <= ST_IDLE;
			end else if (state_q != ST_IDLE && state_q != ST_DRAW) begin
				state_q <= ST_IDLE;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			write_enable <= emit_we;
			byte_address <= emit_addr;
			pixel_word   <= emit_word;
			status       <= emit_status;
			last         <= emit_last;
		end
		if (start_draw) begin
			code_q     <= q_head.code;
			fg_q       <= q_head.fg;
			bg_q       <= q_head.bg;
			dx_q       <= '0;
			dy_q       <= '0;
			pix_addr_q <= start_addr;
			row_addr_q <= start_addr;
		end else if (step) begin
			dy_q <= dy_q + 3'd1;
			if (dy_q == gblit_pkg::LAST_IDX) begin
				dx_q       <= dx_q + 3'd1;
				row_addr_q <= next_row_addr;
				pix_addr_q <= next_row_addr;
			end else begin
				pix_addr_q <= pix_addr_q + AW'(4);
			end
		end
	end

endmodule

@@ rtl/core/glyph_blitter_8x8.sv @@
// 8x8 bitmap-font character blitter for a 32-bit framebuffer. Commands enter
// through a push/full queue interface and results leave through an empty/pop
// queue interface. A load command (opcode 1) writes one glyph row into the
// on-chip font store and produces no result. A draw command (opcode 0) produces
// either one error result (status 1 for a code outside 0x20..0x7E, status 2
// for a cell that runs past the bottom or right edge of the screen) or 64
// framebuffer writes in raster order, the last flagged with last. Drawing a
// glyph whose rows were never loaded returns undefined pixel words. The front
// end classifies each command, packs colors and computes the starting pixel
// index in the cycle it is accepted; a two-deep command queue decouples it
// from the back end, which owns the font RAM and the output register. In the back
// end a good draw first fetches the first glyph row from the registered-read
// font RAM, then makes one pixel write per cycle through the single output
// register, stalling while the consumer holds pop low. Write configuration
// registers only while no command is in flight.
module glyph_blitter_8x8 #(
	parameter int GLYPH_COUNT = gblit_pkg::GLYPH_COUNT,
	parameter int QUEUE_DEPTH = gblit_pkg::QUEUE_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration write port
	input  logic                             cfg_write,
	input  logic [gblit_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gblit_pkg::ADDR_W-1:0]     cfg_data,
	// command side
	input  logic                             push,
	output logic                             full,
	input  logic                             opcode,
	input  logic [11:0]                      cell_row,
	input  logic [11:0]                      cell_col,
	input  logic [7:0]                       char_code,
	input  logic [7:0]                       fg_red,
	input  logic [7:0]                       fg_green,
	input  logic [7:0]                       fg_blue,
	input  logic [7:0]                       bg_red,
	input  logic [7:0]                       bg_green,
	input  logic [7:0]                       bg_blue,
	input  logic [2:0]                       glyph_line,
	input  logic [7:0]                       glyph_bits,
	// result side
	output logic                             empty,
	input  logic                             pop,
	output logic                             write_enable,
	output logic [gblit_pkg::ADDR_W-1:0]     byte_address,
	output logic [gblit_pkg::WORD_W-1:0]     pixel_word,
	output logic [1:0]                       status,
	output logic                             last
);

	gblit_pkg::cfg_t cfg_q;
	gblit_pkg::cmd_t q_data;
	gblit_pkg::cmd_t q_head;
	logic            q_push;
	logic            q_full;
	logic            q_pop;
	logic            q_empty;

	// Register file: unknown indexes are ignored, values masked to field width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				gblit_pkg::CFG_PIX_FMT:       cfg_q.pix_fmt       <= cfg_data[1:0];
				gblit_pkg::CFG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data[12:0];
				gblit_pkg::CFG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data[12:0];
				gblit_pkg::CFG_ROW_STRIDE:    cfg_q.row_stride    <= cfg_data[13:0];
				gblit_pkg::CFG_FRAME_BASE:    cfg_q.frame_base    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Front end: classify and pre-compute per command.
	gblit_front #(
		.GLYPH_COUNT(GLYPH_COUNT)
	) u_front (
		.cfg       (cfg_q),
		.push      (push),
		.full      (full),
		.opcode    (opcode),
		.cell_row  (cell_row),
		.cell_col  (cell_col),
		.char_code (char_code),
		.fg_red    (fg_red),
		.fg_green  (fg_green),
		.fg_blue   (fg_blue),
		.bg_red    (bg_red),
		.bg_green  (bg_green),
		.bg_blue   (bg_blue),
		.glyph_line(glyph_line),
		.glyph_bits(glyph_bits),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_data)
	);

	// Command queue: hold classified commands until the back end is free.
	gblit_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_data),
		.full     (q_full),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty)
	);

	// Back end: apply loads to the font store, emit error results, walk the cell.
	gblit_back #(
		.GLYPH_COUNT(GLYPH_COUNT)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_empty     (q_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.empty       (empty),
		.pop         (pop),
		.write_enable(write_enable),
		.byte_address(byte_address),
		.pixel_word  (pixel_word),
		.status      (status),
		.last        (last)
	);

	// Front never pushes into a full queue.
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("command pushed into full queue");

	// Back never pops an empty queue.
	a_pop_data: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("command popped from empty queue");

	// A non-write result is always a single, final error result.
	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !write_enable) |->
		(last && (status == gblit_pkg::STATUS_NOT_PRINTABLE ||
		          status == gblit_pkg::STATUS_OFF_SCREEN)))
		else $error("malformed error result");

	// Framebuffer writes always carry ok status.
	a_write_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && write_enable) |-> (status == gblit_pkg::STATUS_OK))
		else $error("write result with error status");

endmodule
